// ===== sv/ipf_pkg.sv =====
// Package for the pseudo-float ALU: field widths, command codes and the
// record that travels down the pipeline. No dependencies.
package ipf_pkg;

    localparam int MANT_BITS  = 32;
    localparam int EXPO_BITS  = 16;
    localparam int HALF_SHIFT = 16;
    localparam int DIV_SHIFT  = 15;
    localparam int CROSS_SHIFT = 14;
    localparam int POINT_POS  = 30;
    localparam int NORM_POS   = MANT_BITS - 2;
    localparam int SH_BITS    = $clog2(MANT_BITS);
    localparam int DEN_BITS   = MANT_BITS - DIV_SHIFT;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = MANT_BITS / DIV_STEPS;

    localparam logic [31:0] CROSS_MASK = 32'h8000_FFFF;

    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SUB  = 3'd1;
    localparam logic [2:0] CMD_MUL  = 3'd2;
    localparam logic [2:0] CMD_MULP = 3'd3;
    localparam logic [2:0] CMD_DIV  = 3'd4;
    localparam logic [2:0] CMD_DIVP = 3'd5;
    localparam logic [2:0] CMD_NORM = 3'd6;
    localparam logic [2:0] CMD_INT  = 3'd7;

    typedef struct packed {
        logic [2:0]           cmd;
        logic [MANT_BITS-1:0] am;
        logic [EXPO_BITS-1:0] ae;
        logic [MANT_BITS-1:0] bm;
        logic [EXPO_BITS-1:0] be;
        logic [MANT_BITS-1:0] m;
        logic [EXPO_BITS-1:0] e;
        logic [MANT_BITS-1:0] iv;
        logic                 dz;
        logic [MANT_BITS-1:0] p0;
        logic [MANT_BITS-1:0] p1;
        logic [MANT_BITS-1:0] p2;
        logic [DEN_BITS-1:0]  rem;
        logic [MANT_BITS-1:0] num;
        logic [MANT_BITS-1:0] quo;
        logic [DEN_BITS-1:0]  den;
        logic                 qneg;
        logic [MANT_BITS-1:0] nabs;
        logic [SH_BITS-1:0]   nsh;
    } t_stage;

endpackage

// ===== sv/ipf_div_step.sv =====
// Restoring divider slice: DIV_STEPS quotient bits of the unsigned divide.
// Depends on ipf_pkg.
module ipf_div_step (
    input  ipf_pkg::t_stage i_s,
    output ipf_pkg::t_stage o_s
);
    import ipf_pkg::*;

    always_comb begin
        logic [DEN_BITS:0]    t;
        logic [DEN_BITS-1:0]  rm;
        logic [MANT_BITS-1:0] nm;
        logic [MANT_BITS-1:0] qo;
        o_s = i_s;
        rm  = i_s.rem;
        nm  = i_s.num;
        qo  = i_s.quo;
        for (int j = 0; j < DIV_STEPS; j++) begin
            t  = {rm, nm[MANT_BITS-1]};
            nm = {nm[MANT_BITS-2:0], 1'b0};
            if (t >= {1'b0, i_s.den}) begin
                t  = t - {1'b0, i_s.den};
                qo = {qo[MANT_BITS-2:0], 1'b1};
            end else begin
                qo = {qo[MANT_BITS-2:0], 1'b0};
            end
            rm = t[DEN_BITS-1:0];
        end
        o_s.rem = rm;
        o_s.num = nm;
        o_s.quo = qo;
    end

endmodule

// ===== sv/int_pseudo_float_alu.sv =====
// Pseudo-float ALU top level: fourteen-stage pipeline with an elastic
// stall chain. Depends on ipf_pkg and ipf_div_step.
//
// Use: present a transaction on i_cmd, i_a_*, i_b_* with i_valid; it is
// taken at a rising edge where i_valid is high and o_stall low. Results
// appear on o_res_mant, o_res_expo, o_int_value, o_div_zero with o_valid
// and are taken when i_stall is low.
// One transaction can enter every cycle while o_stall is low; the stages are
// the divider, eight stages of four quotient bits each, plus the input
// register, alignment, quotient sign and three normaliser stages
// (magnitude, leading-one search, shift).
// Each stage holds its own valid bit and loads whenever it is empty or
// its content moves on, so bubbles close up while the receiver stalls;
// o_stall rises only once every stage holds a transaction.
// Reset (i_rst_n low, synchronous) empties the pipeline; nothing else is
// kept between transactions.
module int_pseudo_float_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [2:0]                    i_cmd,
    input  logic [ipf_pkg::MANT_BITS-1:0] i_a_mant,
    input  logic [ipf_pkg::EXPO_BITS-1:0] i_a_expo,
    input  logic [ipf_pkg::MANT_BITS-1:0] i_b_mant,
    input  logic [ipf_pkg::EXPO_BITS-1:0] i_b_expo,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ipf_pkg::MANT_BITS-1:0] o_res_mant,
    output logic [ipf_pkg::EXPO_BITS-1:0] o_res_expo,
    output logic [ipf_pkg::MANT_BITS-1:0] o_int_value,
    output logic                          o_div_zero
);
    import ipf_pkg::*;

    localparam int ST_IN    = 0;
    localparam int ST_ALIGN = 1;
    localparam int ST_DIV0  = 2;
    localparam int ST_QUO   = ST_DIV0 + DIV_STAGES;
    localparam int ST_ABS   = ST_QUO + 1;
    localparam int ST_LZC   = ST_ABS + 1;
    localparam int ST_OUT   = ST_LZC + 1;
    localparam int NSTG     = ST_OUT + 1;

    t_stage           r_s [NSTG];
    t_stage           n_s [NSTG];
    t_stage           w_step [NSTG];
    logic [NSTG-1:0]  r_v;
    logic [NSTG:0]    en;

    always_comb begin
        en[NSTG] = !i_stall;
        for (int k = NSTG - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[ST_IN];

    // input capture
    always_comb begin
        n_s[ST_IN]     = '0;
        n_s[ST_IN].cmd = i_cmd;
        n_s[ST_IN].am  = i_a_mant;
        n_s[ST_IN].ae  = i_a_expo;
        n_s[ST_IN].bm  = i_b_mant;
        n_s[ST_IN].be  = i_b_expo;
    end

    // alignment, products, divider set-up, integer conversion
    always_comb begin
        t_stage               s;
        logic [EXPO_BITS:0]   diff;
        logic [EXPO_BITS:0]   ndiff;
        logic [EXPO_BITS:0]   cs;
        logic [EXPO_BITS:0]   ncs;
        logic [EXPO_BITS-1:0] sh;
        logic [SH_BITS-1:0]   sat;
        logic                 a_gt;
        logic [29:0]          lo_a;
        logic [29:0]          lo_b;
        logic [DEN_BITS-1:0]  d;
        logic                 is_div;
        s     = r_s[ST_ALIGN-1];
        diff  = {s.ae[EXPO_BITS-1], s.ae} - {s.be[EXPO_BITS-1], s.be};
        ndiff = '0 - diff;
        a_gt  = $signed(diff) > 0;
        sh    = a_gt ? diff[EXPO_BITS-1:0] : ndiff[EXPO_BITS-1:0];
        sat   = (sh > EXPO_BITS'(MANT_BITS - 1)) ? SH_BITS'(MANT_BITS - 1)
                                                 : sh[SH_BITS-1:0];
        lo_a  = {s.am[31], 15'b0, s.am[15:2]};
        lo_b  = {s.bm[31], 15'b0, s.bm[15:2]};
        d     = s.bm[MANT_BITS-1:DIV_SHIFT];
        is_div = (s.cmd == CMD_DIV) || (s.cmd == CMD_DIVP);
        cs    = {s.ae[EXPO_BITS-1], s.ae} - (EXPO_BITS+1)'(POINT_POS);
        ncs   = '0 - cs;

        n_s[ST_ALIGN] = s;
        n_s[ST_ALIGN].p0 = MANT_BITS'($signed(s.am[31:16]) * $signed(s.bm[31:16]));
        n_s[ST_ALIGN].p1 = MANT_BITS'({{HALF_SHIFT{s.am[31]}}, s.am[31:16]} * {2'b0, lo_b});
        n_s[ST_ALIGN].p2 = MANT_BITS'({{HALF_SHIFT{s.bm[31]}}, s.bm[31:16]} * {2'b0, lo_a});
        n_s[ST_ALIGN].den  = d[DEN_BITS-1] ? DEN_BITS'('0 - d) : d;
        n_s[ST_ALIGN].dz   = is_div && (d == '0);
        n_s[ST_ALIGN].num  = s.am[MANT_BITS-1] ? ('0 - s.am) : s.am;
        n_s[ST_ALIGN].qneg = s.am[MANT_BITS-1] ^ d[DEN_BITS-1];
        n_s[ST_ALIGN].rem  = '0;
        n_s[ST_ALIGN].quo  = '0;
        n_s[ST_ALIGN].m    = s.am;
        n_s[ST_ALIGN].iv   = '0;

        unique case (s.cmd)
            CMD_ADD, CMD_SUB: begin
                if (a_gt) begin
                    n_s[ST_ALIGN].bm = $signed(s.bm) >>> sat;
                    n_s[ST_ALIGN].e  = s.ae + 1'b1;
                end else begin
                    n_s[ST_ALIGN].am = $signed(s.am) >>> sat;
                    n_s[ST_ALIGN].e  = s.be + 1'b1;
                end
            end
            CMD_MUL, CMD_MULP: n_s[ST_ALIGN].e = s.ae + s.be + EXPO_BITS'(2);
            CMD_DIV:  n_s[ST_ALIGN].e = s.ae - s.be + EXPO_BITS'(DIV_SHIFT);
            CMD_DIVP: n_s[ST_ALIGN].e = s.ae - s.be;
            CMD_NORM: n_s[ST_ALIGN].e = s.ae;
            CMD_INT: begin
                n_s[ST_ALIGN].e = s.ae;
                if (!cs[EXPO_BITS]) begin
                    n_s[ST_ALIGN].iv = (cs >= (EXPO_BITS+1)'(MANT_BITS)) ? '0
                                       : s.am << cs[SH_BITS-1:0];
                end else if (ncs >= (EXPO_BITS+1)'(MANT_BITS - 1)) begin
                    n_s[ST_ALIGN].iv = $signed(s.am) >>> (MANT_BITS - 1);
                end else begin
                    n_s[ST_ALIGN].iv = $signed(s.am) >>> ncs[SH_BITS-1:0];
                end
            end
        endcase
    end

    genvar g;
    generate
        for (g = ST_DIV0; g < ST_QUO; g++) begin : g_div
            ipf_div_step u_step (
                .i_s (r_s[g-1]),
                .o_s (w_step[g])
            );
            if (g == ST_DIV0) begin : g_sum
                always_comb begin
                    t_stage s;
                    s = r_s[g-1];
                    n_s[g] = w_step[g];
                    unique case (s.cmd)
                        CMD_ADD: n_s[g].m = ($signed(s.am) >>> 1) + ($signed(s.bm) >>> 1);
                        CMD_SUB: n_s[g].m = ($signed(s.am) >>> 1) - ($signed(s.bm) >>> 1);
                        CMD_MUL: n_s[g].m = s.p0;
                        CMD_MULP: n_s[g].m = s.p0
                            + {{CROSS_SHIFT{1'b0}}, s.p1[MANT_BITS-1:CROSS_SHIFT]}
                            + {{CROSS_SHIFT{1'b0}}, s.p2[MANT_BITS-1:CROSS_SHIFT]};
                        CMD_DIV, CMD_DIVP, CMD_NORM, CMD_INT: n_s[g].m = s.m;
                    endcase
                end
            end else begin : g_pass
                assign n_s[g] = w_step[g];
            end
        end
        for (g = 0; g < ST_DIV0; g++) begin : g_nostep
            assign w_step[g] = r_s[g];
        end
        for (g = ST_QUO; g < NSTG; g++) begin : g_nostep_tail
            assign w_step[g] = r_s[g];
        end
    endgenerate

    // quotient sign and scaling
    always_comb begin
        t_stage               s;
        logic [MANT_BITS-1:0] q;
        s = r_s[ST_QUO-1];
        q = s.qneg ? ('0 - s.quo) : s.quo;
        n_s[ST_QUO] = s;
        if (s.cmd == CMD_DIV || s.cmd == CMD_DIVP) begin
            if (s.dz) begin
                n_s[ST_QUO].m = '0;
            end else if (s.cmd == CMD_DIVP) begin
                n_s[ST_QUO].m = q << DIV_SHIFT;
            end else begin
                n_s[ST_QUO].m = q;
            end
        end
    end

    always_comb begin
        n_s[ST_ABS]      = r_s[ST_ABS-1];
        n_s[ST_ABS].nabs = r_s[ST_ABS-1].m[MANT_BITS-1] ? ('0 - r_s[ST_ABS-1].m)
                                                        : r_s[ST_ABS-1].m;
    end

    // leading-one search on the magnitude
    always_comb begin
        logic [SH_BITS-1:0] pos;
        pos = '0;
        for (int j = 0; j < MANT_BITS; j++) begin
            if (r_s[ST_LZC-1].nabs[j]) pos = SH_BITS'(j);
        end
        n_s[ST_LZC]     = r_s[ST_LZC-1];
        n_s[ST_LZC].nsh = (pos >= SH_BITS'(NORM_POS)) ? '0 : SH_BITS'(NORM_POS) - pos;
    end

    always_comb begin
        t_stage s;
        s = r_s[ST_OUT-1];
        n_s[ST_OUT] = s;
        if (s.cmd == CMD_INT) begin
            n_s[ST_OUT].m = '0;
            n_s[ST_OUT].e = '0;
        end else begin
            n_s[ST_OUT].iv = '0;
            if (s.m == '0) begin
                n_s[ST_OUT].m = '0;
                n_s[ST_OUT].e = '0;
            end else begin
                n_s[ST_OUT].m = s.m << s.nsh;
                n_s[ST_OUT].e = s.e - {{(EXPO_BITS-SH_BITS){1'b0}}, s.nsh};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) r_v[k] <= (k == 0) ? i_valid : r_v[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (en[k]) r_s[k] <= n_s[k];
        end
    end

    assign o_valid     = r_v[ST_OUT];
    assign o_res_mant  = r_s[ST_OUT].m;
    assign o_res_expo  = r_s[ST_OUT].e;
    assign o_int_value = r_s[ST_OUT].iv;
    assign o_div_zero  = r_s[ST_OUT].dz;

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_zero |-> o_res_mant == '0 && o_res_expo == '0)
        else $error("divide by zero result not cleared");

    a_int_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_int_value != '0 |-> o_res_mant == '0 && o_res_expo == '0
            && !o_div_zero)
        else $error("integer result mixed with float result");

    a_normed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res_mant != '0 |->
            (o_res_mant[MANT_BITS-1] != o_res_mant[MANT_BITS-2])
            || (o_res_mant == {2'b11, {(MANT_BITS-2){1'b0}}}))
        else $error("result mantissa not normalised");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("pipeline not empty after reset");

endmodule
